// ===== src/gamepad_report_decoder_assert.svh =====
// assertion macros for the gamepad report decoder
// expects clk_i and rst_ni in the including module's scope
`ifndef GAMEPAD_REPORT_DECODER_ASSERT_SVH
`define GAMEPAD_REPORT_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define GPD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("gamepad report decoder assertion failed");

`define GPD_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("gamepad report decoder forbidden condition");

`else

`define GPD_ASSERT(name, prop)

`define GPD_ASSERT_NEVER(name, cond)

`endif

`endif

// ===== src/gpd_pkg.sv =====
// shared types and constants for the gamepad report decoder
// no dependencies
package gpd_pkg;

  localparam int unsigned WinLen = 9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  report_kind;
    logic        has_data;
    logic        stuck_loop;
    logic [7:0]  right_buttons;
    logic [7:0]  middle_buttons;
    logic [7:0]  left_buttons;
    logic [11:0] left_x;
    logic [11:0] left_y;
    logic [11:0] right_x;
    logic [11:0] right_y;
  } out_item_t;

  typedef enum logic [2:0] {
    KIND_EMPTY = 3'd0,
    KIND_STD   = 3'd1,
    KIND_CTRL  = 3'd2,
    KIND_ECHO  = 3'd3,
    KIND_BAD   = 3'd4
  } kind_e;

  typedef logic [WinLen-1:0][7:0] window_t;

  // report state as seen with the current byte folded in
  typedef struct packed {
    logic [5:0] idx;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    window_t    field_bytes;
  } snap_t;

  localparam logic [7:0] FirstEmpty  = 8'h00;
  localparam logic [7:0] FirstStdA   = 8'h21;
  localparam logic [7:0] FirstStdB   = 8'h30;
  localparam logic [7:0] FirstStdC   = 8'h31;
  localparam logic [7:0] FirstCtrl   = 8'h3F;
  localparam logic [7:0] FirstEcho   = 8'h81;
  localparam logic [7:0] SecondStuck = 8'h01;

  localparam logic [5:0] StdBase     = 6'd3;
  localparam logic [5:0] EchoBase    = 6'd13;
  localparam logic [5:0] StdLastIdx  = 6'd12;
  localparam logic [5:0] EchoLastIdx = 6'd21;
  localparam logic [5:0] CountMax    = 6'd63;

  localparam logic [7:0] SideMask    = 8'hCF;
  localparam logic [7:0] MiddleMask  = 8'h3F;

endpackage

// ===== src/gamepad_report_decoder.sv =====
// top level of the gamepad report decoder: input register, state, result register
// depends on gpd_pkg, gpd_capture, gpd_format, gamepad_report_decoder_assert.svh
//
// Takes one report byte per item and one item per clock while the input is not
// backed up. A byte sits in the input register while the report state is
// updated; the last byte of a report, held in the input register, produces a
// result item that is registered in the output register. Input backs up only
// when a last byte waits behind a result that has not yet been taken; a stalled
// result never blocks non-final bytes. Results only carry button and stick data
// for standard input reports of 13 or more bytes and request echoes of 22 or more bytes.
`include "gamepad_report_decoder_assert.svh"

module gamepad_report_decoder import gpd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_o
);

  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;
  logic      out_free, s1_go, in_take;
  snap_t     snap;
  out_item_t res;
  logic      out_kind_data, out_kind_echo_bad;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_go      = s1_valid_q && (!s1_q.last_byte || out_free);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_take    = in_valid_i && in_ready_o;

  gpd_capture u_capture (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .commit_i    (s1_go),
    .data_byte_i (s1_q.data_byte),
    .last_byte_i (s1_q.last_byte),
    .snap_o      (snap)
  );

  gpd_format u_format (
    .snap_i (snap),
    .res_o  (res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_go && s1_q.last_byte) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q <= in_i;
    end
    if (s1_go && s1_q.last_byte) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign out_kind_data     = (out_q.report_kind == KIND_STD) || (out_q.report_kind == KIND_ECHO);
  assign out_kind_echo_bad = (out_q.report_kind == KIND_ECHO) || (out_q.report_kind == KIND_BAD);

  // a result only appears after a final byte was processed
  `GPD_ASSERT(a_result_after_last, $rose(out_valid_q) |-> $past(s1_go && s1_q.last_byte))
  // the byte counter restarts once a report is finished
  `GPD_ASSERT(a_count_restart, (s1_go && s1_q.last_byte) |=> (snap.idx == 6'd0))
  // data flag tracks the kinds that carry fields
  `GPD_ASSERT(a_data_kind, out_valid_q |-> (out_q.has_data == out_kind_data))
  // stuck loop only arises on echo-headed reports
  `GPD_ASSERT_NEVER(a_stuck_kind, out_valid_q && out_q.stuck_loop && !out_kind_echo_bad)

endmodule

// ===== src/gpd_capture.sv =====
// report state: byte counter, first and second byte, nine-byte field window
// depends on gpd_pkg
module gpd_capture import gpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       commit_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output snap_t      snap_o
);

  logic [5:0] count_q, count_d;
  logic [7:0] first_q, first_d;
  logic [7:0] second_q, second_d;
  window_t    win_q, win_d;
  logic [5:0] base;

  always_comb begin
    snap_o.idx         = count_q;
    snap_o.first_byte  = (count_q == 6'd0) ? data_byte_i : first_q;
    snap_o.second_byte = (count_q == 6'd1) ? data_byte_i : second_q;
    base = (snap_o.first_byte == FirstEcho) ? EchoBase : StdBase;
    for (int j = 0; j < WinLen; j++) begin
      snap_o.field_bytes[j] = (count_q == base + 6'(j)) ? data_byte_i : win_q[j];
    end
  end

  always_comb begin
    if (last_byte_i) begin
      count_d  = '0;
      first_d  = '0;
      second_d = '0;
      win_d    = '0;
    end else begin
      count_d  = (count_q == CountMax) ? count_q : count_q + 6'd1;
      first_d  = snap_o.first_byte;
      second_d = snap_o.second_byte;
      win_d    = snap_o.field_bytes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      first_q  <= '0;
      second_q <= '0;
      win_q    <= '0;
    end else if (commit_i) begin
      count_q  <= count_d;
      first_q  <= first_d;
      second_q <= second_d;
      win_q    <= win_d;
    end
  end

endmodule

// ===== src/gpd_format.sv =====
// classifies the report and unpacks buttons and sticks into a result item
// depends on gpd_pkg
module gpd_format import gpd_pkg::*; (
  input  snap_t     snap_i,
  output out_item_t res_o
);

  kind_e   kind;
  logic    data;
  window_t w;

  assign w = snap_i.field_bytes;

  always_comb begin
    unique case (snap_i.first_byte) inside
      FirstEmpty:                       kind = KIND_EMPTY;
      FirstStdA, FirstStdB, FirstStdC:  kind = (snap_i.idx >= StdLastIdx) ? KIND_STD : KIND_BAD;
      FirstCtrl:                        kind = KIND_CTRL;
      FirstEcho:                        kind = (snap_i.idx >= EchoLastIdx) ? KIND_ECHO : KIND_BAD;
      default:                          kind = KIND_BAD;
    endcase
  end

  assign data = (kind == KIND_STD) || (kind == KIND_ECHO);

  always_comb begin
    res_o             = '0;
    res_o.report_kind = kind;
    res_o.has_data    = data;
    res_o.stuck_loop  = (snap_i.first_byte == FirstEcho) && (snap_i.second_byte == SecondStuck);
    if (data) begin
      res_o.right_buttons  = w[0] & SideMask;
      res_o.middle_buttons = w[1] & MiddleMask;
      res_o.left_buttons   = w[2] & SideMask;
      res_o.left_x         = {w[4][3:0], w[3]};
      res_o.left_y         = {w[5], w[4][7:4]};
      res_o.right_x        = {w[7][3:0], w[6]};
      res_o.right_y        = {w[8], w[7][7:4]};
    end
  end

endmodule
